>>> rtl/core/ncr_pkg.sv
// ----------------------------------------------------------------------------
// ncr_pkg
// shared types, constants and utf-8 helpers for the numeric reference decoder
// ----------------------------------------------------------------------------
package ncr_pkg;

	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] COUNT_SAT = 7'd127;

	// characters of interest
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_Z_UP = 8'h5a;
	localparam logic [7:0] CH_A_LO = 8'h61;

	// codepoint range limits
	localparam logic [31:0] CP_1B_MAX = 32'h0000_007f;
	localparam logic [31:0] CP_2B_MAX = 32'h0000_07ff;
	localparam logic [31:0] CP_3B_MAX = 32'h0000_ffff;
	localparam logic [31:0] CP_MAX    = 32'h0010_ffff;

	// utf-8 byte constants
	localparam logic [7:0] REPL_B0 = 8'hef;
	localparam logic [7:0] REPL_B1 = 8'hbf;
	localparam logic [7:0] REPL_B2 = 8'hbd;
	localparam logic [7:0] LEAD_2B = 8'hc0;
	localparam logic [7:0] LEAD_3B = 8'he0;
	localparam logic [7:0] LEAD_4B = 8'hf0;
	localparam logic [7:0] CONT_B  = 8'h80;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_UTF     = 4'b0010,
		S_ECHO_RD = 4'b0100,
		S_ECHO_LD = 4'b1000
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic load;
		logic rd_en;
		logic rd_next;
		logic done;
	} ncr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic numeric;
		logic last;
		logic out_free;
	} ncr_sts_t;

	function automatic logic [31:0] digit_value(input logic [7:0] c, input logic hex);
		logic [31:0] c32;
		c32 = {24'd0, c};
		if ((c >= CH_0 && c <= CH_9) || !hex)
			return c32 - {24'd0, CH_0};
		else if (c >= CH_A_UP && c <= CH_Z_UP)
			return c32 - {24'd0, CH_A_UP} + 32'd10;
		else
			return c32 - {24'd0, CH_A_LO} + 32'd10;
	endfunction

	function automatic logic cp_invalid(input logic [31:0] cp);
		return (cp == 32'd0) || (cp > CP_MAX);
	endfunction

	// index of the last utf-8 byte for a codepoint
	function automatic logic [1:0] utf8_last(input logic [31:0] cp);
		if (cp_invalid(cp))
			return 2'd2;
		else if (cp <= CP_1B_MAX)
			return 2'd0;
		else if (cp <= CP_2B_MAX)
			return 2'd1;
		else if (cp <= CP_3B_MAX)
			return 2'd2;
		else
			return 2'd3;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [1:0] k);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		b0 = 8'd0;
		b1 = 8'd0;
		b2 = 8'd0;
		b3 = 8'd0;
		if (cp_invalid(cp)) begin
			b0 = REPL_B0;
			b1 = REPL_B1;
			b2 = REPL_B2;
		end else if (cp <= CP_1B_MAX) begin
			b0 = cp[7:0];
		end else if (cp <= CP_2B_MAX) begin
			b0 = LEAD_2B | {3'd0, cp[10:6]};
			b1 = CONT_B | {2'd0, cp[5:0]};
		end else if (cp <= CP_3B_MAX) begin
			b0 = LEAD_3B | {4'd0, cp[15:12]};
			b1 = CONT_B | {2'd0, cp[11:6]};
			b2 = CONT_B | {2'd0, cp[5:0]};
		end else begin
			b0 = LEAD_4B | {5'd0, cp[20:18]};
			b1 = CONT_B | {2'd0, cp[17:12]};
			b2 = CONT_B | {2'd0, cp[11:6]};
			b3 = CONT_B | {2'd0, cp[5:0]};
		end
		case (k)
			2'd0: return b0;
			2'd1: return b1;
			2'd2: return b2;
			default: return b3;
		endcase
	endfunction

endpackage

>>> rtl/core/numeric_char_ref_to_utf8_top.sv
// ----------------------------------------------------------------------------
// numeric_char_ref_to_utf8_top
// decodes numeric character references to utf-8, echoes other entities
// ----------------------------------------------------------------------------
// sequence: a non-final character is taken while idle; after the final request the
//   utf-8 bytes are loaded into the output register, echo bytes after a registered ram read
// throughput: 1 character per cycle while idle, then the input stalls for the whole burst
//   of 1..4 utf-8 bytes or the echo of len bytes, including any output stalls
// reset: arst_n clears the sequencer, character count, codepoint, mode flags and output
//   valid; the echo ram is not cleared, only written entries are read
module numeric_char_ref_to_utf8_top
	import ncr_pkg::*;
#(
	parameter int MAX_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// input channel: one entity character per request
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       final_char,
	// output channel: one result byte per request
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       truncated
);

	// command and status between sequencer and datapath
	ncr_cmd_t cmd;
	ncr_sts_t sts;

	// sequencer: idle collects characters, then runs the burst for the entity
	ncr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.final_char (final_char),
		.sts        (sts),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	// datapath: accumulator, echo buffer and the output register
	ncr_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.final_char (final_char),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.truncated  (truncated)
	);

`ifndef SYNTHESIS
	// a result is never loaded over one that is still held by a stall
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(out_valid && out_stall))
		else $error("output register overwritten while stalled");

	// the end of an entity always starts a burst that stalls the input
	a_final_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && final_char) |=> in_stall)
		else $error("input not stalled after final character");

	// a character that is not final produces no result
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !final_char) |=> !cmd.load)
		else $error("result produced before final character");

	// results are only loaded while the input side is held off
	a_load_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_stall)
		else $error("result loaded while accepting characters");
`endif

endmodule

>>> rtl/core/ncr_ram.sv
// ----------------------------------------------------------------------------
// ncr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ncr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/ncr_ctrl.sv
// ----------------------------------------------------------------------------
// ncr_ctrl
// sequencer: collects characters, then steps the utf-8 or echo burst
// ----------------------------------------------------------------------------
module ncr_ctrl
	import ncr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     final_char,
	input  ncr_sts_t sts,
	output logic     in_stall,
	output ncr_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (final_char)
						state_d = sts.numeric ? S_UTF : S_ECHO_RD;
				end
			end
			S_UTF: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.last) begin
						cmd.done = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_ECHO_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_ECHO_LD;
			end
			S_ECHO_LD: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.last) begin
						cmd.done = 1'b1;
						state_d  = S_IDLE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> rtl/core/ncr_dp.sv
// ----------------------------------------------------------------------------
// ncr_dp
// datapath: entity state, codepoint accumulator, echo buffer, output register
// ----------------------------------------------------------------------------
module ncr_dp
	import ncr_pkg::*;
#(
	parameter int MAX_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_in,
	input  logic       final_char,
	input  logic       out_stall,
	input  ncr_cmd_t   cmd,
	output ncr_sts_t   sts,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       truncated
);

	localparam int AW = $clog2(MAX_LEN);
	localparam logic [CNT_W-1:0] LEN_C  = CNT_W'(MAX_LEN);
	localparam logic [AW-1:0]    LAST_C = AW'(MAX_LEN - 1);

	logic [CNT_W-1:0] char_count_q;
	logic [31:0]      code_accum_q;
	logic             hex_mode_q;
	logic             hash_seen_q;
	logic             numeric_q;
	logic             trunc_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    last_idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_end_q;
	logic             truncated_q;

	logic             numeric;
	logic             over_len;
	logic             new_hex;
	logic             acc_upd;
	logic             hex_sel;
	logic [31:0]      mul10;
	logic [31:0]      mul16;
	logic [31:0]      acc_next;
	logic [AW-1:0]    echo_last;
	logic [AW-1:0]    raddr;
	logic [7:0]       rdata;
	logic             we;

	assign numeric   = (char_count_q >= CNT_W'(3)) && hash_seen_q;
	assign over_len  = char_count_q >= LEN_C;
	assign echo_last = over_len ? LAST_C : char_count_q[AW-1:0];
	assign new_hex   = (char_in == CH_X_UP) || (char_in == CH_X_LO);
	assign hex_sel   = (char_count_q >= CNT_W'(3)) && hex_mode_q;
	assign acc_upd   = ((char_count_q == CNT_W'(2)) && !new_hex) ||
	                   (char_count_q >= CNT_W'(3));
	assign mul10     = {code_accum_q[28:0], 3'd0} + {code_accum_q[30:0], 1'b0};
	assign mul16     = {code_accum_q[27:0], 4'd0};
	assign acc_next  = (hex_sel ? mul16 : mul10) + digit_value(char_in, hex_sel);

	assign we    = cmd.take && !over_len;
	assign raddr = cmd.rd_next ? (idx_q + AW'(1)) : idx_q;

	ncr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LEN)
	) u_echo_ram (
		.clk   (clk),
		.we    (we),
		.waddr (char_count_q[AW-1:0]),
		.wdata (char_in),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// entity state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			code_accum_q <= '0;
			hex_mode_q   <= 1'b0;
			hash_seen_q  <= 1'b0;
			numeric_q    <= 1'b0;
			trunc_q      <= 1'b0;
			idx_q        <= '0;
			last_idx_q   <= '0;
		end else if (cmd.take) begin
			if (final_char) begin
				char_count_q <= '0;
				hex_mode_q   <= 1'b0;
				hash_seen_q  <= 1'b0;
				numeric_q    <= numeric;
				trunc_q      <= !numeric && over_len;
				idx_q        <= '0;
				last_idx_q   <= numeric ? AW'(utf8_last(code_accum_q)) : echo_last;
			end else begin
				if (char_count_q == CNT_W'(1))
					hash_seen_q <= (char_in == CH_HASH);
				if (char_count_q == CNT_W'(2))
					hex_mode_q <= new_hex;
				if (acc_upd)
					code_accum_q <= acc_next;
				if (char_count_q != COUNT_SAT)
					char_count_q <= char_count_q + CNT_W'(1);
			end
		end else begin
			if (cmd.load)
				idx_q <= idx_q + AW'(1);
			if (cmd.done)
				code_accum_q <= '0;
		end
	end

	// output register
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.numeric  = numeric;
	assign sts.last     = (idx_q == last_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q  <= numeric_q ? utf8_byte(code_accum_q, idx_q[1:0]) : rdata;
			run_end_q   <= (idx_q == last_idx_q);
			truncated_q <= trunc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;
	assign truncated = truncated_q;

endmodule
